// ===== sv/s256_pkg.sv =====
package s256_pkg;

   typedef logic [31:0] word_type;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_PAD   = 6'b000010,
      ST_LOAD  = 6'b000100,
      ST_ROUND = 6'b001000,
      ST_ADD   = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   localparam word_type IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [7:0] APPEND_BYTE = 8'h80;

   function automatic word_type rotr(word_type x, int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

endpackage

// ===== sv/sha256_byte_stream_hasher_unit.sv =====
// SHA-256 hasher fed one message byte per item.
// Input channel req_*: data_byte (valid when has_byte), has_byte, end_of_message.
// Accepted when req_valid && !req_stall. req_stall is high while the block is
// busy with a compression, padding or digest output.
// Output channel rsp_*: eight digest words, word_index 0..7, last_word on 7.
// A byte that does not fill a block is taken without a stall, so such bytes
// go back to back. The 64th byte of a block starts a compression: a prefetch
// state (LOAD), 16 rounds that each load their word from the buffer, one byte
// read per cycle, 48 rounds fed from the message schedule, then add-back of
// the eight words on one shared adder; input is stalled throughout.
// An end mark pads byte by byte in the buffer up to offset 63, compresses,
// and if the length did not fit pads and compresses a second block; then
// offers the eight words one per cycle while rsp_stall is low.
// rsp_stall holds the current word; input stays stalled until word 7 goes.
// The byte buffer is a 64 x 8 memory with a registered read.
// Reset (synchronous, active high) restores the initial hash words and
// clears the fill count and bit count; the buffer needs no clearing.
module sha256_byte_stream_hasher_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   s256_pkg::state_type state_ff, state_in;
   s256_pkg::word_type  hash_ff [8];
   s256_pkg::word_type  var_ff  [8];
   s256_pkg::word_type  win_ff  [16];
   logic [7:0]  mem [64];
   logic [7:0]  rd_ff;
   logic [5:0]  fill_ff;
   logic [63:0] bits_ff;
   logic [5:0]  round_ff;
   logic [1:0]  sub_ff;       // byte within a word during load
   logic [2:0]  idx_ff;       // add-back / emit index
   logic        final_ff;     // 0x80 already written for this message
   logic        lenphase_ff;  // current pad block carries the length
   logic        pend_ff;      // end mark waits behind a full-block compression
   logic [23:0] acc_ff;       // upper bytes of the word being loaded

   logic        wr_en;
   logic [5:0]  wr_addr;
   logic [7:0]  wr_data;
   logic [5:0]  rd_addr;
   logic [63:0] len_sh;

   wire accept = req_valid && !req_stall;
   assign req_stall = (state_ff != s256_pkg::ST_IDLE);

   // buffer memory
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   // round datapath
   logic [3:0] wi;
   s256_pkg::word_type w_new, w_sched, t1, t2, wa, wb;
   always_comb begin
      wi = round_ff[3:0];
      wa = win_ff[4'(wi - 4'd2)];
      wb = win_ff[4'(wi - 4'd15)];
      w_sched = (s256_pkg::rotr(wa, 17) ^ s256_pkg::rotr(wa, 19) ^ (wa >> 10))
              + win_ff[4'(wi - 4'd7)]
              + (s256_pkg::rotr(wb, 7) ^ s256_pkg::rotr(wb, 18) ^ (wb >> 3))
              + win_ff[wi];
      w_new = (round_ff < 6'd16) ? {acc_ff, rd_ff} : w_sched;
      t1 = var_ff[7] + (s256_pkg::rotr(var_ff[4], 6) ^ s256_pkg::rotr(var_ff[4], 11)
         ^ s256_pkg::rotr(var_ff[4], 25))
         + ((var_ff[4] & var_ff[5]) ^ (~var_ff[4] & var_ff[6]))
         + s256_pkg::K[round_ff] + w_new;
      t2 = (s256_pkg::rotr(var_ff[0], 2) ^ s256_pkg::rotr(var_ff[0], 13)
         ^ s256_pkg::rotr(var_ff[0], 22))
         + ((var_ff[0] & var_ff[1]) ^ (var_ff[0] & var_ff[2]) ^ (var_ff[1] & var_ff[2]));
   end

   // in rounds < 16 the word is ready on the last byte of its load
   wire round_go = (round_ff >= 6'd16) || (sub_ff == 2'd3 && state_ff == s256_pkg::ST_ROUND);

   always_comb begin
      state_in = state_ff;
      wr_en = 1'b0;
      wr_addr = fill_ff;
      wr_data = req_data_byte;
      rd_addr = 6'd0;   // LOAD prefetches byte 0
      // length byte for offset 56 + k sits in the top byte after shifting k bytes
      len_sh = bits_ff << {fill_ff[2:0], 3'b000};
      case (state_ff)
         s256_pkg::ST_IDLE: begin
            if (accept && req_has_byte) wr_en = 1'b1;
            if (accept && req_has_byte && fill_ff == 6'd63) state_in = s256_pkg::ST_LOAD;
            else if (accept && req_end_of_message) state_in = s256_pkg::ST_PAD;
         end
         s256_pkg::ST_PAD: begin
            wr_en = 1'b1;
            if (!final_ff) wr_data = s256_pkg::APPEND_BYTE;
            else if (lenphase_ff && fill_ff >= 6'd56) wr_data = len_sh[63:56];
            else wr_data = 8'h00;
            if (fill_ff == 6'd63) state_in = s256_pkg::ST_LOAD;
         end
         s256_pkg::ST_LOAD: state_in = s256_pkg::ST_ROUND;
         s256_pkg::ST_ROUND: begin
            if (sub_ff != 2'd3 && round_ff < 6'd16) rd_addr = {round_ff[3:0], 2'(sub_ff + 2'd1)};
            else rd_addr = {4'(round_ff[3:0] + 4'd1), 2'd0};
            if (round_go && round_ff == 6'd63) state_in = s256_pkg::ST_ADD;
         end
         s256_pkg::ST_ADD: begin
            if (idx_ff == 3'd7) begin
               if (lenphase_ff) state_in = s256_pkg::ST_EMIT;
               else if (final_ff || pend_ff) state_in = s256_pkg::ST_PAD;
               else state_in = s256_pkg::ST_IDLE;
            end
         end
         s256_pkg::ST_EMIT: begin
            if (!rsp_stall && idx_ff == 3'd7) state_in = s256_pkg::ST_IDLE;
         end
         default: state_in = s256_pkg::ST_IDLE;
      endcase
   end

   // lenphase_ff is set when 0x80 lands below offset 56, or when the block
   // after a too-full pad block starts.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= s256_pkg::ST_IDLE;
         hash_ff <= s256_pkg::IV;
         fill_ff <= '0;
         bits_ff <= '0;
         round_ff <= '0;
         sub_ff <= '0;
         idx_ff <= '0;
         final_ff <= 1'b0;
         lenphase_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            s256_pkg::ST_IDLE: begin
               if (accept && req_has_byte) begin
                  fill_ff <= fill_ff + 6'd1;
                  bits_ff <= bits_ff + 64'd8;
                  // byte completing a block with end mark: pad after compression
                  if (fill_ff == 6'd63) pend_ff <= req_end_of_message;
               end
            end
            s256_pkg::ST_PAD: begin
               fill_ff <= fill_ff + 6'd1;
               final_ff <= 1'b1;
               pend_ff <= 1'b0;
               if (!final_ff && fill_ff < 6'd56) lenphase_ff <= 1'b1;
            end
            s256_pkg::ST_LOAD: begin
               var_ff <= hash_ff;
               round_ff <= '0;
               sub_ff <= 2'd0;
            end
            s256_pkg::ST_ROUND: begin
               if (round_ff < 6'd16 && sub_ff != 2'd3) begin
                  sub_ff <= sub_ff + 2'd1;
                  acc_ff <= {acc_ff[15:0], rd_ff};
               end
               if (round_go) begin
                  sub_ff <= 2'd0;
                  win_ff[wi] <= w_new;
                  var_ff[7] <= var_ff[6]; var_ff[6] <= var_ff[5];
                  var_ff[5] <= var_ff[4]; var_ff[4] <= var_ff[3] + t1;
                  var_ff[3] <= var_ff[2]; var_ff[2] <= var_ff[1];
                  var_ff[1] <= var_ff[0]; var_ff[0] <= t1 + t2;
                  round_ff <= round_ff + 6'd1;
                  if (round_ff == 6'd63) idx_ff <= '0;
               end
            end
            s256_pkg::ST_ADD: begin
               hash_ff[idx_ff] <= hash_ff[idx_ff] + var_ff[idx_ff];
               idx_ff <= idx_ff + 3'd1;
               // length did not fit: the next pad block carries it
               if (idx_ff == 3'd7 && final_ff) lenphase_ff <= 1'b1;
            end
            s256_pkg::ST_EMIT: begin
               if (!rsp_stall) begin
                  idx_ff <= idx_ff + 3'd1;
                  if (idx_ff == 3'd7) begin
                     hash_ff <= s256_pkg::IV;
                     fill_ff <= '0;
                     bits_ff <= '0;
                     lenphase_ff <= 1'b0;
                     final_ff <= 1'b0;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid       = (state_ff == s256_pkg::ST_EMIT);
   assign rsp_digest_word = hash_ff[idx_ff];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = (idx_ff == 3'd7);

   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("accept during digest");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_word_index)))
      else $error("digest word dropped");
   a_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_word) |=> !rsp_valid)
      else $error("extra digest word");
endmodule
